// ===== hw/rtl/mrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrm_pkg: shared types and constants of the Modbus RTU master framer
// Holds the command, result-kind and error codes, the CRC-16 byte update and
// the structs that pass between the input register, the core and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package mrm_pkg;

  // Default number of register words a read may return
  localparam int DEFAULT_MAX_REGS = 4;

  // Counter width covering eight request bytes and up to eight words
  localparam int CNT_W = 4;

  // Request bytes before the CRC, and the full request length
  localparam int FRAME_BYTES = 6;
  localparam int TX_LEN      = 8;

  localparam logic [7:0]  SLAVE_ID_RESET = 8'h01;
  localparam logic [7:0]  FC_READ        = 8'h04;
  localparam logic [15:0] CRC_SEED       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [4:0]  ECHO_LEN       = 5'd8;
  localparam logic [4:0]  HDR_LEN        = 5'd5;

  // Input commands
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_WORD    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // Verdict codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd1;
  localparam logic [2:0] ERR_SLAVE_ID = 3'd2;
  localparam logic [2:0] ERR_FUNC     = 3'd3;
  localparam logic [2:0] ERR_CRC      = 3'd4;
  localparam logic [2:0] ERR_COUNT    = 3'd5;
  localparam logic [2:0] ERR_BAD_REQ  = 3'd6;

  // Transaction phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT
  } phase_t;

  // One input item
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] value_or_count;
    logic [7:0]  rx_byte;
  } item_t;

  // Burst handed from the core to the emitter
  typedef struct packed {
    logic                             is_tx;
    logic [FRAME_BYTES-1:0][7:0]      frame;
    logic [CNT_W-1:0]                 nwords;
    logic [2:0]                       err;
  } burst_t;

  // Fold one byte into a reflected CRC-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mrm_in_reg.sv =====
// ----------------------------------------------------------------------------
// mrm_in_reg: input holding register
// Captures one input transfer and holds it until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_in_reg
  import mrm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output      logic  in_stall,
  input  wire item_t in_item,
  input  wire logic  consume,
  output      logic  item_valid,
  output      item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // Stall only while a held item is not consumed
  assign in_stall = valid_r && !consume;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload of the accepted transfer
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mrm_core.sv =====
// ----------------------------------------------------------------------------
// mrm_core: transaction state of the framer
// Checks received bytes, folds them into the running CRC, stores register
// words and hands a result burst to the emitter for every item that has one.
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_core
  import mrm_pkg::*;
#(
  parameter int MAX_REGS = DEFAULT_MAX_REGS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        item_valid,
  input  wire item_t       item,
  output      logic        consume,
  input  wire logic        emit_ready,
  output      logic        burst_valid,
  output      burst_t      burst,
  output      logic [15:0] words [MAX_REGS]
);

  logic [7:0]       slave_id_r;
  phase_t           phase_r,  phase_nxt;
  logic [4:0]       exp_len_r, exp_len_nxt;
  logic [4:0]       rcv_cnt_r, rcv_cnt_nxt;
  logic [15:0]      crc_r,     crc_nxt;
  logic [7:0]       req_code_r, req_code_nxt;
  logic [CNT_W-1:0] req_cnt_r,  req_cnt_nxt;
  logic [2:0]       err_r,     err_nxt;
  logic [7:0]       hold_r,    hold_nxt;
  logic [15:0]      words_r [MAX_REGS];

  logic             bad_req;
  logic             frame_end;
  logic             has_res;
  logic             word_we;
  logic [CNT_W-1:0] word_idx;
  logic [15:0]      word_data;
  logic [5:0]       pos_p2;
  logic [5:0]       pos_p1;
  logic [5:0]       len_x;
  logic [4:0]       off;

  assign pos_p2 = {1'b0, rcv_cnt_r} + 6'd2;
  assign pos_p1 = {1'b0, rcv_cnt_r} + 6'd1;
  assign len_x  = {1'b0, exp_len_r};
  assign off    = rcv_cnt_r - 5'd3;

  // Read with a zero count or more words than stored is refused
  assign bad_req = (item.function_code == FC_READ) &&
                   ((item.value_or_count == 16'd0) ||
                    (item.value_or_count > 16'(MAX_REGS)));

  // Byte that completes the response
  assign frame_end = (item.cmd == CMD_BYTE) && (phase_r == PH_WAIT) && (pos_p1 >= len_x);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (item.cmd)
      CMD_START: begin
        phase_nxt = bad_req ? PH_IDLE : PH_WAIT;
      end
      CMD_TIMEOUT: begin
        phase_nxt = PH_IDLE;
      end
      CMD_BYTE: begin
        if (frame_end) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // Datapath update and result burst
  always_comb begin
    exp_len_nxt  = exp_len_r;
    rcv_cnt_nxt  = rcv_cnt_r;
    crc_nxt      = crc_r;
    req_code_nxt = req_code_r;
    req_cnt_nxt  = req_cnt_r;
    err_nxt      = err_r;
    hold_nxt     = hold_r;
    has_res      = 1'b0;
    word_we      = 1'b0;
    word_idx     = off[4:1];
    word_data    = {hold_r, item.rx_byte};
    burst        = '0;

    case (item.cmd)
      CMD_START: begin
        has_res = 1'b1;
        if (bad_req) begin
          burst.err = ERR_BAD_REQ;
        end else begin
          burst.is_tx    = 1'b1;
          burst.frame[0] = slave_id_r;
          burst.frame[1] = item.function_code;
          burst.frame[2] = item.register_address[15:8];
          burst.frame[3] = item.register_address[7:0];
          burst.frame[4] = item.value_or_count[15:8];
          burst.frame[5] = item.value_or_count[7:0];
          req_code_nxt   = item.function_code;
          if (item.function_code == FC_READ) begin
            req_cnt_nxt = item.value_or_count[CNT_W-1:0];
            exp_len_nxt = HDR_LEN + {item.value_or_count[3:0], 1'b0};
          end else begin
            req_cnt_nxt = '0;
            exp_len_nxt = ECHO_LEN;
          end
          rcv_cnt_nxt = 5'd0;
          crc_nxt     = CRC_SEED;
          err_nxt     = ERR_OK;
          hold_nxt    = 8'd0;
        end
      end

      CMD_TIMEOUT: begin
        if (phase_r == PH_WAIT) begin
          has_res   = 1'b1;
          burst.err = ERR_TIMEOUT;
        end
      end

      CMD_BYTE: begin
        if (phase_r == PH_WAIT) begin
          if (pos_p2 < len_x) begin
            // Header and data bytes: check, store, fold into the CRC
            if (rcv_cnt_r == 5'd0) begin
              if (item.rx_byte != slave_id_r && err_r == ERR_OK) begin
                err_nxt = ERR_SLAVE_ID;
              end
            end else if (rcv_cnt_r == 5'd1) begin
              if (item.rx_byte != req_code_r && err_r == ERR_OK) begin
                err_nxt = ERR_FUNC;
              end
            end else if (rcv_cnt_r == 5'd2) begin
              if (req_code_r == FC_READ && err_r == ERR_OK &&
                  item.rx_byte != {3'd0, req_cnt_r, 1'b0}) begin
                err_nxt = ERR_COUNT;
              end
            end else if (req_code_r == FC_READ) begin
              if (!off[0]) begin
                hold_nxt = item.rx_byte;
              end else if (word_idx < CNT_W'(MAX_REGS)) begin
                word_we = 1'b1;
              end
            end
            crc_nxt = crc_byte(crc_r, item.rx_byte);
          end else if (pos_p2 == len_x) begin
            // CRC low byte
            if (item.rx_byte != crc_r[7:0] && (err_r == ERR_OK || err_r == ERR_COUNT)) begin
              err_nxt = ERR_CRC;
            end
          end else begin
            // CRC high byte
            if (item.rx_byte != crc_r[15:8] && (err_r == ERR_OK || err_r == ERR_COUNT)) begin
              err_nxt = ERR_CRC;
            end
          end
          rcv_cnt_nxt = rcv_cnt_r + 5'd1;
          if (frame_end) begin
            has_res   = 1'b1;
            burst.err = err_nxt;
            if (err_nxt == ERR_OK && req_code_r == FC_READ) begin
              burst.nwords = req_cnt_r;
            end
          end
        end
      end

      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  // Consume an item once its burst, if any, has a place
  assign consume     = item_valid && (!has_res || emit_ready);
  assign burst_valid = item_valid && has_res && emit_ready;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r <= SLAVE_ID_RESET;
      phase_r    <= PH_IDLE;
      exp_len_r  <= 5'd0;
      rcv_cnt_r  <= 5'd0;
      crc_r      <= CRC_SEED;
      req_code_r <= 8'd0;
      req_cnt_r  <= '0;
      err_r      <= ERR_OK;
      hold_r     <= 8'd0;
    end else begin
      if (cfg_we) begin
        slave_id_r <= cfg_wdata;
      end
      if (consume) begin
        phase_r    <= phase_nxt;
        exp_len_r  <= exp_len_nxt;
        rcv_cnt_r  <= rcv_cnt_nxt;
        crc_r      <= crc_nxt;
        req_code_r <= req_code_nxt;
        req_cnt_r  <= req_cnt_nxt;
        err_r      <= err_nxt;
        hold_r     <= hold_nxt;
      end
    end
  end

  // Register word store, one write enable per entry
  for (genvar i = 0; i < MAX_REGS; i++) begin : g_word
    always_ff @(posedge clk) begin
      if (consume && word_we && word_idx == CNT_W'(i)) begin
        words_r[i] <= word_data;
      end
    end
    assign words[i] = words_r[i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mrm_emit.sv =====
// ----------------------------------------------------------------------------
// mrm_emit: result sequencer and output register
// Plays out one burst a result per transfer: the six request bytes and their
// two CRC bytes, or the stored register words followed by the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module mrm_emit
  import mrm_pkg::*;
#(
  parameter int MAX_REGS = DEFAULT_MAX_REGS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        burst_valid,
  input  wire burst_t      burst,
  input  wire logic [15:0] words [MAX_REGS],
  output      logic        emit_ready,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  out_kind,
  output      logic [7:0]  out_tx_byte,
  output      logic [2:0]  out_register_index,
  output      logic [15:0] out_register_value,
  output      logic        out_ok,
  output      logic [2:0]  out_error_code,
  output      logic        out_last
);

  localparam int IW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  logic                        busy_r;
  logic                        is_tx_r;
  logic [FRAME_BYTES-1:0][7:0] frame_r;
  logic [CNT_W-1:0]            nwords_r;
  logic [2:0]                  err_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [15:0]                 crc_r;
  logic                        out_valid_r;
  logic [1:0]                  kind_r;
  logic [7:0]                  tx_byte_r;
  logic [2:0]                  reg_idx_r;
  logic [15:0]                 reg_val_r;
  logic                        ok_r;
  logic [2:0]                  err_out_r;
  logic                        last_r;

  logic                        load;
  logic                        final_res;
  logic                        in_frame;
  logic [7:0]                  frame_byte;
  logic [7:0]                  tx_sel;

  // Load the output register when it is empty or being drained
  assign load      = busy_r && (!out_valid_r || !out_stall);
  assign final_res = is_tx_r ? (cnt_r == CNT_W'(TX_LEN - 1)) : (cnt_r == nwords_r);
  assign emit_ready = !busy_r || (load && final_res);

  // Select the request byte: header bytes, then CRC low and high
  assign in_frame   = cnt_r < CNT_W'(FRAME_BYTES);
  assign frame_byte = frame_r[cnt_r[2:0]];
  always_comb begin
    if (in_frame) begin
      tx_sel = frame_byte;
    end else if (cnt_r == CNT_W'(FRAME_BYTES)) begin
      tx_sel = crc_r[7:0];
    end else begin
      tx_sel = crc_r[15:8];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= load || (out_valid_r && out_stall);
      if (load) begin
        cnt_r <= cnt_r + 1'b1;
        if (final_res) begin
          busy_r <= 1'b0;
        end
      end
      if (burst_valid) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  // Burst payload and request CRC
  always_ff @(posedge clk) begin
    if (load && is_tx_r && in_frame) begin
      crc_r <= crc_byte(crc_r, frame_byte);
    end
    if (burst_valid) begin
      is_tx_r  <= burst.is_tx;
      frame_r  <= burst.frame;
      nwords_r <= burst.nwords;
      err_r    <= burst.err;
      crc_r    <= CRC_SEED;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte_r <= 8'd0;
      reg_idx_r <= 3'd0;
      reg_val_r <= 16'd0;
      ok_r      <= 1'b0;
      err_out_r <= ERR_OK;
      last_r    <= final_res;
      if (is_tx_r) begin
        kind_r    <= KIND_TX;
        tx_byte_r <= tx_sel;
      end else if (!final_res) begin
        kind_r    <= KIND_WORD;
        reg_idx_r <= cnt_r[2:0];
        reg_val_r <= words[cnt_r[IW-1:0]];
      end else begin
        kind_r    <= KIND_VERDICT;
        ok_r      <= (err_r == ERR_OK);
        err_out_r <= err_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_tx_byte        = tx_byte_r;
  assign out_register_index = reg_idx_r;
  assign out_register_value = reg_val_r;
  assign out_ok             = ok_r;
  assign out_error_code     = err_out_r;
  assign out_last           = last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/modbus_rtu_master_framer_unit.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_master_framer_unit: Modbus RTU master framer with CRC-16
// Builds requests, checks responses and reports register words and verdicts.
//
// Channels: the input channel carries commands (start a request, one
// received byte, receive timeout); the output channel carries results
// (request bytes, register words, verdicts), the last one of an item marked
// by out_last. Both use valid/stall; a transfer happens when valid is high
// and stall is low. cfg_we writes cfg_wdata into the slave address.
// Path: the first result of an item passes the input register, the
// emitter's burst registers and then the output register.
// Throughput: an item without results never waits for the emitter; one with
// results waits in the input register until the burst before it is done.
// Results go out one per cycle through the output register while out_stall
// is low; a valid start gives eight, a completed read the words and a verdict.
// Reset: synchronous, active low; the slave address returns to 1, the
// transaction goes idle and both channels are empty.
// Stall: a stalled result holds in the output register; items without results
// are still taken meanwhile, and one with results is held until its results have a place.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_master_framer_unit
  import mrm_pkg::*;
#(
  parameter int MAX_REGS = DEFAULT_MAX_REGS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_function_code,
  input  wire logic [15:0] in_register_address,
  input  wire logic [15:0] in_value_or_count,
  input  wire logic [7:0]  in_rx_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [1:0]  out_kind,
  output      logic [7:0]  out_tx_byte,
  output      logic [2:0]  out_register_index,
  output      logic [15:0] out_register_value,
  output      logic        out_ok,
  output      logic [2:0]  out_error_code,
  output      logic        out_last
);

  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        consume;
  logic        emit_ready;
  logic        burst_valid;
  burst_t      burst;
  logic [15:0] words [MAX_REGS];

  // Gather the input payload
  assign in_item.cmd              = in_cmd;
  assign in_item.function_code    = in_function_code;
  assign in_item.register_address = in_register_address;
  assign in_item.value_or_count   = in_value_or_count;
  assign in_item.rx_byte          = in_rx_byte;

  mrm_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  mrm_core #(
    .MAX_REGS (MAX_REGS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_valid  (item_valid),
    .item        (item),
    .consume     (consume),
    .emit_ready  (emit_ready),
    .burst_valid (burst_valid),
    .burst       (burst),
    .words       (words)
  );

  mrm_emit #(
    .MAX_REGS (MAX_REGS)
  ) u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .burst_valid        (burst_valid),
    .burst              (burst),
    .words              (words),
    .emit_ready         (emit_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_tx_byte        (out_tx_byte),
    .out_register_index (out_register_index),
    .out_register_value (out_register_value),
    .out_ok             (out_ok),
    .out_error_code     (out_error_code),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the Modbus RTU master framer unit
// A queue-fed driver sends start, received-byte and timeout commands; every
// accepted transfer runs through a cycle-free model of the framer that
// builds the request bytes, checks the response and queues the awaited
// results. A monitor compares each result transfer field by field. The run
// covers directed corner cases and then random request/response exchanges
// with faults, under several slave addresses and idling mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import mrm_pkg::*;

  localparam int MAX_REGS      = DEFAULT_MAX_REGS;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 100;
  localparam int PHASE_ITEMS   = 32;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_SLAVE,
    FAULT_FUNC,
    FAULT_COUNT,
    FAULT_CRC,
    FAULT_DATA,
    FAULT_TIMEOUT,
    FAULT_ABANDON,
    FAULT_MIXED
  } fault_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        ok;
    logic [2:0]  error_code;
    logic        last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_TIMEOUT;
  logic [7:0]  in_function_code = 8'h00;
  logic [15:0] in_register_address = 16'h0000;
  logic [15:0] in_value_or_count = 16'h0000;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_tx_byte;
  logic [2:0]  out_register_index;
  logic [15:0] out_register_value;
  logic        out_ok;
  logic [2:0]  out_error_code;
  logic        out_last;

  idle_mode_t    idle_mode = IDLE_NONE;
  item_t         pending_items[$];
  item_t         item_on_bus;
  frame_result_t awaited_results[$];
  int            mismatch_count = 0;
  int            useful_items = 0;

  // Framer model state
  logic [7:0]  slave_addr = SLAVE_ID_RESET;
  phase_t      link_phase = PH_IDLE;
  logic [4:0]  reply_len = 5'd0;
  logic [4:0]  resp_seen = 5'd0;
  logic [15:0] resp_crc = CRC_SEED;
  logic [7:0]  req_code = 8'h00;
  logic [3:0]  req_count = 4'd0;
  logic [2:0]  err_latch = ERR_OK;
  logic [7:0]  word_high = 8'h00;
  logic [15:0] reg_words [MAX_REGS];

  modbus_rtu_master_framer_unit #(
    .MAX_REGS(MAX_REGS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_function_code   (in_function_code),
    .in_register_address(in_register_address),
    .in_value_or_count  (in_value_or_count),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_tx_byte        (out_tx_byte),
    .out_register_index (out_register_index),
    .out_register_value (out_register_value),
    .out_ok             (out_ok),
    .out_error_code     (out_error_code),
    .out_last           (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Reflected CRC-16 update over one byte
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] c;
    c = acc ^ {8'h00, data};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] tx,
                             input logic [2:0] idx, input logic [15:0] val,
                             input logic ok, input logic [2:0] err, input logic last);
    awaited_results.push_back('{kind, tx, idx, val, ok, err, last});
  endtask

  // Advance the framer model by one accepted item and queue its results
  task automatic predict_framer(input item_t it);
    logic [7:0]  frame [TX_LEN];
    logic [15:0] crc;
    logic        crc_bad;
    int          pos;
    int          len;
    int          off;
    case (it.cmd)
      CMD_START: begin
        if (it.function_code == FC_READ &&
            (it.value_or_count == 16'd0 || it.value_or_count > MAX_REGS)) begin
          link_phase = PH_IDLE;
          push_result(KIND_VERDICT, 8'h00, 3'd0, 16'h0000, 1'b0, ERR_BAD_REQ, 1'b1);
        end else begin
          frame[0] = slave_addr;
          frame[1] = it.function_code;
          frame[2] = it.register_address[15:8];
          frame[3] = it.register_address[7:0];
          frame[4] = it.value_or_count[15:8];
          frame[5] = it.value_or_count[7:0];
          crc = CRC_SEED;
          for (int i = 0; i < FRAME_BYTES; i++) crc = crc16_fold(crc, frame[i]);
          frame[6] = crc[7:0];
          frame[7] = crc[15:8];
          for (int i = 0; i < TX_LEN; i++) begin
            push_result(KIND_TX, frame[i], 3'd0, 16'h0000, 1'b0, ERR_OK, i == TX_LEN - 1);
          end
          link_phase = PH_WAIT;
          req_code   = it.function_code;
          req_count  = (it.function_code == FC_READ) ? it.value_or_count[3:0] : 4'd0;
          reply_len  = (it.function_code == FC_READ) ?
                       HDR_LEN + 5'(2 * it.value_or_count) : ECHO_LEN;
          resp_seen  = 5'd0;
          resp_crc   = CRC_SEED;
          err_latch  = ERR_OK;
          word_high  = 8'h00;
        end
      end
      CMD_TIMEOUT: begin
        if (link_phase == PH_WAIT) begin
          link_phase = PH_IDLE;
          push_result(KIND_VERDICT, 8'h00, 3'd0, 16'h0000, 1'b0, ERR_TIMEOUT, 1'b1);
        end
      end
      CMD_BYTE: begin
        if (link_phase == PH_WAIT) begin
          pos = int'(resp_seen);
          len = int'(reply_len);
          crc_bad = 1'b0;
          if (pos + 2 < len) begin
            // Header checks in priority order, then the register payload
            if (pos == 0) begin
              if (it.rx_byte != slave_addr && err_latch == ERR_OK) err_latch = ERR_SLAVE_ID;
            end else if (pos == 1) begin
              if (it.rx_byte != req_code && err_latch == ERR_OK) err_latch = ERR_FUNC;
            end else if (pos == 2) begin
              if (req_code == FC_READ && it.rx_byte != 8'(2 * req_count) &&
                  err_latch == ERR_OK) err_latch = ERR_COUNT;
            end else if (req_code == FC_READ) begin
              off = pos - 3;
              if (off % 2 == 0) begin
                word_high = it.rx_byte;
              end else if (off / 2 < MAX_REGS) begin
                reg_words[off / 2] = {word_high, it.rx_byte};
              end
            end
            resp_crc = crc16_fold(resp_crc, it.rx_byte);
          end else if (pos + 2 == len) begin
            crc_bad = (it.rx_byte != resp_crc[7:0]);
          end else begin
            crc_bad = (it.rx_byte != resp_crc[15:8]);
          end
          // A CRC failure outranks a byte-count error only
          if (crc_bad && (err_latch == ERR_OK || err_latch == ERR_COUNT)) err_latch = ERR_CRC;
          resp_seen = resp_seen + 5'd1;
          if (pos + 1 >= len) begin
            link_phase = PH_IDLE;
            if (err_latch == ERR_OK && req_code == FC_READ) begin
              for (int i = 0; i < int'(req_count) && i < MAX_REGS; i++) begin
                push_result(KIND_WORD, 8'h00, 3'(i), reg_words[i], 1'b0, ERR_OK, 1'b0);
              end
            end
            push_result(KIND_VERDICT, 8'h00, 3'd0, 16'h0000, err_latch == ERR_OK,
                        err_latch, 1'b1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    frame_result_t want;
    string         diffs;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing awaited: kind %0d", out_kind));
    end else begin
      want = awaited_results.pop_front();
      diffs = "";
      if (out_kind !== want.kind)
        diffs = {diffs, $sformatf(" kind %0d/%0d", out_kind, want.kind)};
      if (out_tx_byte !== want.tx_byte)
        diffs = {diffs, $sformatf(" tx_byte %h/%h", out_tx_byte, want.tx_byte)};
      if (out_register_index !== want.reg_index)
        diffs = {diffs, $sformatf(" index %0d/%0d", out_register_index, want.reg_index)};
      if (out_register_value !== want.reg_value)
        diffs = {diffs, $sformatf(" value %h/%h", out_register_value, want.reg_value)};
      if (out_ok !== want.ok)
        diffs = {diffs, $sformatf(" ok %b/%b", out_ok, want.ok)};
      if (out_error_code !== want.error_code)
        diffs = {diffs, $sformatf(" error %0d/%0d", out_error_code, want.error_code)};
      if (out_last !== want.last)
        diffs = {diffs, $sformatf(" last %b/%b", out_last, want.last)};
      if (diffs != "") report_mismatch({"result got/want:", diffs});
    end
  endtask

  // Drive the input channel; predict on every accepted transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_framer(item_on_bus);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 &&
            !((idle_mode == IDLE_SENDER && chance(61)) ||
              (idle_mode == IDLE_BOTH && chance(31)))) begin
          item_on_bus = pending_items.pop_front();
          in_valid            <= 1'b1;
          in_cmd              <= item_on_bus.cmd;
          in_function_code    <= item_on_bus.function_code;
          in_register_address <= item_on_bus.register_address;
          in_value_or_count   <= item_on_bus.value_or_count;
          in_rx_byte          <= item_on_bus.rx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check result transfers and drive the receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= (idle_mode == IDLE_RECEIVER) ? chance(61) :
                   (idle_mode == IDLE_BOTH) ? chance(31) : 1'b0;
    end
  end

  function automatic item_t random_item(input logic [1:0] cmd);
    item_t it;
    it.cmd              = cmd;
    it.function_code    = 8'($urandom);
    it.register_address = 16'($urandom);
    it.value_or_count   = 16'($urandom);
    it.rx_byte          = 8'($urandom);
    return it;
  endfunction

  task automatic queue_item(input item_t it);
    pending_items.push_back(it);
    useful_items++;
  endtask

  task automatic queue_start(input logic [7:0] fc, input logic [15:0] addr,
                             input logic [15:0] voc);
    item_t it;
    it = random_item(CMD_START);
    it.function_code    = fc;
    it.register_address = addr;
    it.value_or_count   = voc;
    queue_item(it);
  endtask

  // Queue a request and the slave's response, damaged as the fault asks
  task automatic queue_exchange(input logic [7:0] fc, input logic [15:0] addr,
                                input logic [15:0] voc, input fault_t fault);
    logic [7:0]  resp[$];
    logic [15:0] crc;
    item_t       it;
    int          sent;
    queue_start(fc, addr, voc);
    resp.push_back(slave_addr);
    resp.push_back(fc);
    if (fc == FC_READ) begin
      resp.push_back(8'(2 * voc));
      for (int i = 0; i < 2 * int'(voc); i++) begin
        case ($urandom_range(0, 3))
          0:       resp.push_back(8'h00);
          1:       resp.push_back(8'hFF);
          default: resp.push_back(8'($urandom));
        endcase
      end
    end else begin
      resp.push_back(addr[15:8]);
      resp.push_back(addr[7:0]);
      resp.push_back(voc[15:8]);
      resp.push_back(voc[7:0]);
    end
    // Header faults go in before the CRC so the CRC check does not trip on them
    case (fault)
      FAULT_SLAVE: resp[0] ^= 8'($urandom_range(1, 255));
      FAULT_FUNC:  resp[1] ^= 8'($urandom_range(1, 255));
      FAULT_COUNT: resp[2] ^= 8'($urandom_range(1, 255));
      FAULT_MIXED: begin
        for (int i = 0; i < 3; i++) begin
          if (chance(50)) resp[i] ^= 8'($urandom_range(1, 255));
        end
      end
      default: ;
    endcase
    crc = CRC_SEED;
    foreach (resp[i]) crc = crc16_fold(crc, resp[i]);
    resp.push_back(crc[7:0]);
    resp.push_back(crc[15:8]);
    case (fault)
      FAULT_CRC:  resp[resp.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      FAULT_DATA: resp[$urandom_range(2, resp.size() - 3)] ^= 8'($urandom_range(1, 255));
      FAULT_MIXED: begin
        if (chance(50)) resp[$urandom_range(0, resp.size() - 1)] ^= 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    sent = (fault == FAULT_TIMEOUT || fault == FAULT_ABANDON) ?
           $urandom_range(0, resp.size() - 1) : resp.size();
    for (int i = 0; i < sent; i++) begin
      it = random_item(CMD_BYTE);
      it.rx_byte = resp[i];
      queue_item(it);
    end
    if (fault == FAULT_TIMEOUT) queue_item(random_item(CMD_TIMEOUT));
  endtask

  task automatic queue_random_phase(input int n_items);
    int          first;
    int          pick;
    logic [7:0]  fc;
    logic [15:0] voc;
    fault_t      fault;
    item_t       it;
    first = useful_items;
    while (useful_items - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // Noise: commands that an idle block drops
        case ($urandom_range(0, 2))
          0:       it = random_item(CMD_BYTE);
          1:       it = random_item(CMD_TIMEOUT);
          default: it = random_item(2'd3);
        endcase
        pending_items.push_back(it);
      end else if (pick < 15) begin
        voc = chance(30) ? 16'd0 : chance(30) ? 16'hFFFF : 16'($urandom_range(MAX_REGS + 1, 65535));
        queue_start(FC_READ, 16'($urandom), voc);
      end else begin
        if (chance(50)) begin
          fc  = FC_READ;
          voc = 16'($urandom_range(1, MAX_REGS));
        end else begin
          fc  = chance(30) ? 8'h06 : 8'($urandom);
          if (fc == FC_READ) fc = 8'h06;
          voc = 16'($urandom);
        end
        fault = chance(55) ? FAULT_NONE : fault_t'($urandom_range(FAULT_SLAVE, FAULT_MIXED));
        queue_exchange(fc, 16'($urandom), voc, fault);
      end
    end
  endtask

  task automatic write_slave_id(input logic [7:0] id);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slave_addr = id;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Run watchdog
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners at the reset slave address, no idling
    idle_mode <= IDLE_NONE;
    queue_start(FC_READ, 16'h1234, 16'd0);
    queue_start(FC_READ, 16'h1234, 16'(MAX_REGS + 1));
    queue_start(FC_READ, 16'h0000, 16'hFFFF);
    pending_items.push_back(random_item(CMD_BYTE));
    pending_items.push_back(random_item(CMD_TIMEOUT));
    pending_items.push_back(random_item(2'd3));
    // Abandon a pending write, then a full-size read
    queue_start(8'h06, 16'h0000, 16'h0000);
    queue_exchange(FC_READ, 16'hFFFF, 16'(MAX_REGS), FAULT_NONE);
    queue_start(8'hFF, 16'hFFFF, 16'hFFFF);
    queue_item(random_item(CMD_TIMEOUT));
    wait_drained();

    write_slave_id(8'h00);
    idle_mode <= IDLE_NONE;
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    write_slave_id(8'hFF);
    idle_mode <= IDLE_SENDER;
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    write_slave_id(8'($urandom));
    idle_mode <= IDLE_RECEIVER;
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    write_slave_id(8'($urandom));
    idle_mode <= IDLE_BOTH;
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/mrm_pkg.sv
hw/rtl/mrm_in_reg.sv
hw/rtl/mrm_core.sv
hw/rtl/mrm_emit.sv
hw/rtl/modbus_rtu_master_framer_unit.sv
sim/tb.sv
